### sv/pedestrian_velocity_update_assert.svh
// Assertion shorthands shared by the RTL.
`ifndef PEDESTRIAN_VELOCITY_UPDATE_ASSERT_SVH
`define PEDESTRIAN_VELOCITY_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PVU_ASSERT_COMB(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PVU_ASSERT_SEQ(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pvu_pkg.sv
`timescale 1ns / 1ps

package pvu_pkg;

  // Configuration register indexes
  localparam logic CFG_FRICTION_COEF = 1'b0;
  localparam logic CFG_TIME_STEP     = 1'b1;

  localparam logic [30:0] TIME_STEP_RST = 31'd3277;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Per-item context carried along the pipeline
  typedef struct packed {
    logic               halt;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] s;
    logic [30:0]        mass;
    logic [30:0]        rt;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               nx;
    logic               ny;
    logic               lenz;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] d;
    logic signed [31:0] latx;
    logic signed [31:0] laty;
    logic signed [31:0] prx;
    logic signed [31:0] pry;
    logic signed [31:0] frx;
    logic signed [31:0] fry;
    logic               ovx;
    logic               ovy;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
  } ctx_t;

  // Magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Signed word from sign and magnitude, saturating
  function automatic logic signed [31:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      return (m >= 64'h8000_0000) ? S32_MIN : $signed(~m[31:0] + 32'd1);
    end
    return (m > 64'h7FFF_FFFF) ? S32_MAX : $signed(m[31:0]);
  endfunction

  // Round a Q32.32 magnitude product to Q16.16, half away from zero
  function automatic logic signed [31:0] rnd_q(input logic neg, input logic [63:0] p);
    logic [63:0] m;
    m = (p + 64'h8000) >> 16;
    return from_mag(neg, m);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] t;
    t = 33'(a) + 33'(b);
    if (t[32] != t[31]) return t[32] ? S32_MIN : S32_MAX;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] t;
    t = 33'(a) - 33'(b);
    if (t[32] != t[31]) return t[32] ? S32_MIN : S32_MAX;
    return t[31:0];
  endfunction

  // Finish a rounded division: overflow saturates, zero divisor with zero
  // dividend gives zero
  function automatic logic signed [31:0] fin_div(input logic neg, input logic ovf,
                                                 input logic dz, input logic [30:0] q);
    if (ovf) return neg ? S32_MIN : S32_MAX;
    if (dz) return 32'sd0;
    return from_mag(neg, 64'(q));
  endfunction

endpackage

### sv/pvu_div.sv
`timescale 1ns / 1ps

// Two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. Each numerator must be below den * 2^QW.
module pvu_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_a,
  input  logic [NW-1:0] in_num_b,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo_a,
  output logic [QW-1:0] out_quo_b,
  output logic [SW-1:0] out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld  [1:QW];
  logic [NW-1:0] ra   [1:QW];
  logic [NW-1:0] rb   [1:QW];
  logic [DW-1:0] den  [1:QW];
  logic [QW-1:0] qa   [1:QW];
  logic [QW-1:0] qb   [1:QW];
  logic [SW-1:0] side [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic          vs;
    logic [NW-1:0] as, bs;
    logic [DW-1:0] ds;
    logic [QW-1:0] qas, qbs;
    logic [SW-1:0] ss;
    logic [CW-1:0] dsh;
    logic          ge_a, ge_b;

    if (k == 0) begin : g_first
      assign vs  = in_valid;
      assign as  = in_num_a;
      assign bs  = in_num_b;
      assign ds  = in_den;
      assign qas = '0;
      assign qbs = '0;
      assign ss  = in_side;
    end else begin : g_rest
      assign vs  = vld[k];
      assign as  = ra[k];
      assign bs  = rb[k];
      assign ds  = den[k];
      assign qas = qa[k];
      assign qbs = qb[k];
      assign ss  = side[k];
    end

    // Trial subtract of the shifted divisor
    assign dsh  = CW'(ds) << B;
    assign ge_a = CW'(as) >= dsh;
    assign ge_b = CW'(bs) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra[k+1]   <= ge_a ? NW'(CW'(as) - dsh) : as;
        rb[k+1]   <= ge_b ? NW'(CW'(bs) - dsh) : bs;
        qa[k+1]   <= qas | (ge_a ? (QW'(1) << B) : '0);
        qb[k+1]   <= qbs | (ge_b ? (QW'(1) << B) : '0);
        den[k+1]  <= ds;
        side[k+1] <= ss;
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo_a = qa[QW];
  assign out_quo_b = qb[QW];
  assign out_side  = side[QW];

endmodule

### sv/pedestrian_velocity_update.sv
`timescale 1ns / 1ps

// Social-force velocity and position step for one pedestrian, Q16.16 fixed
// point. The block takes one item per clock and delivers one result per item;
// the whole datapath stalls together when the result is not taken, so input
// ready is low only while the output register holds an unaccepted beat. The
// latency is dominated by the 32-stage square root of the goal distance and by
// three restoring dividers (17 stages for the unit direction, 31 for the mass
// over reaction time scaling, 31 for the division by mass). friction_coef and
// time_step are written through the cfg port, which is always ready, and must
// only change while no item is in flight. A halted item returns zero velocity
// and its position unchanged.
`include "pedestrian_velocity_update_assert.svh"

module pedestrian_velocity_update (
  input  logic         clk,
  input  logic         rst,
  // tdata: pos_x, pos_y, vel_x, vel_y, goal_x, goal_y (32 each),
  //        desired_speed, mass, reaction_time, slow_factor (31 each), 4 zero bits
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [319:0] s_axis_tdata,
  // tuser: halt
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: new_vel_x, new_vel_y, new_pos_x, new_pos_y (32 each)
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CtxW = $bits(pvu_pkg::ctx_t);

  logic        en;
  logic [30:0] friction_coef;
  logic [30:0] time_step;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      friction_coef <= '0;
      time_step     <= pvu_pkg::TIME_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pvu_pkg::CFG_FRICTION_COEF: friction_coef <= cfg_data[30:0];
        pvu_pkg::CFG_TIME_STEP:     time_step     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Advance every stage unless the output beat is stalled
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic v14, v15, v16, v17, v18, v19, v20, v21;
  logic vd1, vd2, vd3;

  pvu_pkg::ctx_t c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12, c13;
  pvu_pkg::ctx_t c14, c15, c16, c17, c18, c19, c20;
  pvu_pkg::ctx_t cd1, cd2, cd3;

  // Square root stage registers
  logic          sq_v [1:32];
  logic [63:0]   sq_x [1:32];
  logic [63:0]   sq_r [1:32];
  pvu_pkg::ctx_t sq_c [1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;  v2 <= 1'b0;  v3 <= 1'b0;  v4 <= 1'b0;
      v6 <= 1'b0;  v7 <= 1'b0;  v8 <= 1'b0;  v9 <= 1'b0;
      v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0;
      v14 <= 1'b0; v15 <= 1'b0; v16 <= 1'b0; v17 <= 1'b0;
      v18 <= 1'b0; v19 <= 1'b0; v20 <= 1'b0; v21 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid; v2 <= v1; v3 <= v2; v4 <= v3;
      v6 <= vd1; v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9;
      v11 <= v10; v12 <= v11; v13 <= v12;
      v14 <= vd2; v15 <= v14; v16 <= v15;
      v17 <= vd3; v18 <= v17; v19 <= v18; v20 <= v19; v21 <= v20;
      v5 <= sq_v[32];
    end
  end

  // Stage 1: register the input beat
  logic signed [31:0] gx1, gy1;
  logic [30:0]        spd1, slow1;

  always_ff @(posedge clk) begin
    if (en) begin
      c1      <= '0;
      c1.halt <= s_axis_tuser;
      c1.px   <= s_axis_tdata[31:0];
      c1.py   <= s_axis_tdata[63:32];
      c1.vx   <= s_axis_tdata[95:64];
      c1.vy   <= s_axis_tdata[127:96];
      c1.mass <= s_axis_tdata[253:223];
      c1.rt   <= s_axis_tdata[284:254];
      gx1     <= s_axis_tdata[159:128];
      gy1     <= s_axis_tdata[191:160];
      spd1    <= s_axis_tdata[222:192];
      slow1   <= s_axis_tdata[315:285];
    end
  end

  // Stage 2: goal difference, magnitudes halved when too wide; target speed
  logic signed [32:0] dx2, dy2;
  logic [32:0]        adx2, ady2;
  logic               big2;
  logic [61:0]        sp2;

  assign dx2  = 33'(gx1) - 33'(c1.px);
  assign dy2  = 33'(gy1) - 33'(c1.py);
  assign adx2 = dx2[32] ? (~dx2 + 33'd1) : dx2;
  assign ady2 = dy2[32] ? (~dy2 + 33'd1) : dy2;
  assign big2 = adx2[32] | adx2[31] | ady2[32] | ady2[31];
  assign sp2  = 62'(spd1) * 62'(slow1);

  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c1;
      c2.ax <= big2 ? adx2[32:1] : adx2[31:0];
      c2.ay <= big2 ? ady2[32:1] : ady2[31:0];
      c2.nx <= dx2[32];
      c2.ny <= dy2[32];
      c2.s  <= pvu_pkg::rnd_q(1'b0, 64'(sp2));
    end
  end

  // Stage 3: squares
  logic [63:0] sqx3, sqy3;

  always_ff @(posedge clk) begin
    if (en) begin
      c3   <= c2;
      sqx3 <= 64'(c2.ax) * 64'(c2.ax);
      sqy3 <= 64'(c2.ay) * 64'(c2.ay);
    end
  end

  // Stage 4: squared length
  logic [63:0] x4;

  always_ff @(posedge clk) begin
    if (en) begin
      c4 <= c3;
      x4 <= sqx3 + sqy3;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar gi = 0; gi < 32; gi++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * gi);
    logic          vs;
    logic [63:0]   xs, rs, trial;
    pvu_pkg::ctx_t cs;

    if (gi == 0) begin : g_first
      assign vs = v4;
      assign xs = x4;
      assign rs = '0;
      assign cs = c4;
    end else begin : g_rest
      assign vs = sq_v[gi];
      assign xs = sq_x[gi];
      assign rs = sq_r[gi];
      assign cs = sq_c[gi];
    end

    assign trial = rs + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[gi+1] <= 1'b0;
      end else if (en) begin
        sq_v[gi+1] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[gi+1] <= cs;
        if (xs >= trial) begin
          sq_x[gi+1] <= xs - trial;
          sq_r[gi+1] <= (rs >> 1) + Bit;
        end else begin
          sq_x[gi+1] <= xs;
          sq_r[gi+1] <= rs >> 1;
        end
      end
    end
  end

  // Stage 5: direction numerators, rounded by half the length
  logic [31:0] len5;
  logic [47:0] nux5, nuy5;
  logic [31:0] den5;

  assign len5 = sq_r[32][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      c5      <= sq_c[32];
      c5.lenz <= (len5 == 32'd0);
      nux5    <= {sq_c[32].ax, 16'd0} + 48'(len5 >> 1);
      nuy5    <= {sq_c[32].ay, 16'd0} + 48'(len5 >> 1);
      den5    <= len5;
    end
  end

  logic [16:0]     qux, quy;
  logic [CtxW-1:0] cd1_bits;

  pvu_div #(.NW(48), .DW(32), .QW(17), .SW(CtxW)) u_div_dir (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_num_a  (nux5),
    .in_num_b  (nuy5),
    .in_den    (den5),
    .in_side   (c5),
    .out_valid (vd1),
    .out_quo_a (qux),
    .out_quo_b (quy),
    .out_side  (cd1_bits)
  );

  assign cd1 = cd1_bits;

  // Stage 6: signed unit direction, zero for a zero length
  logic [31:0] uxm6, uym6;

  assign uxm6 = 32'(qux);
  assign uym6 = 32'(quy);

  always_ff @(posedge clk) begin
    if (en) begin
      c6    <= cd1;
      c6.ux <= cd1.lenz ? 32'sd0 : (cd1.nx ? $signed(~uxm6 + 32'd1) : $signed(uxm6));
      c6.uy <= cd1.lenz ? 32'sd0 : (cd1.ny ? $signed(~uym6 + 32'd1) : $signed(uym6));
    end
  end

  // Stage 7: v.u partial products
  logic [63:0] pvx7, pvy7;

  always_ff @(posedge clk) begin
    if (en) begin
      c7   <= c6;
      pvx7 <= 64'(pvu_pkg::abs32(c6.vx)) * 64'(pvu_pkg::abs32(c6.ux));
      pvy7 <= 64'(pvu_pkg::abs32(c6.vy)) * 64'(pvu_pkg::abs32(c6.uy));
    end
  end

  // Stage 8: forward speed
  always_ff @(posedge clk) begin
    if (en) begin
      c8   <= c7;
      c8.d <= pvu_pkg::add_sat(pvu_pkg::rnd_q(c7.vx[31] ^ c7.ux[31], pvx7),
                               pvu_pkg::rnd_q(c7.vy[31] ^ c7.uy[31], pvy7));
    end
  end

  // Stage 9: forward velocity and desired velocity products
  logic [63:0] pdx9, pdy9, psx9, psy9;

  always_ff @(posedge clk) begin
    if (en) begin
      c9   <= c8;
      pdx9 <= 64'(pvu_pkg::abs32(c8.d)) * 64'(pvu_pkg::abs32(c8.ux));
      pdy9 <= 64'(pvu_pkg::abs32(c8.d)) * 64'(pvu_pkg::abs32(c8.uy));
      psx9 <= 64'(pvu_pkg::abs32(c8.ux)) * 64'(c8.s[30:0]);
      psy9 <= 64'(pvu_pkg::abs32(c8.uy)) * 64'(c8.s[30:0]);
    end
  end

  // Stage 10: sideways velocity and velocity error
  always_ff @(posedge clk) begin
    if (en) begin
      c10      <= c9;
      c10.latx <= pvu_pkg::sub_sat(c9.vx, pvu_pkg::rnd_q(c9.d[31] ^ c9.ux[31], pdx9));
      c10.laty <= pvu_pkg::sub_sat(c9.vy, pvu_pkg::rnd_q(c9.d[31] ^ c9.uy[31], pdy9));
      c10.prx  <= pvu_pkg::sub_sat(pvu_pkg::rnd_q(c9.ux[31], psx9), c9.vx);
      c10.pry  <= pvu_pkg::sub_sat(pvu_pkg::rnd_q(c9.uy[31], psy9), c9.vy);
    end
  end

  // Stage 11: friction and mass products
  logic [63:0] pfx11, pfy11, pmx11, pmy11;

  always_ff @(posedge clk) begin
    if (en) begin
      c11   <= c10;
      pfx11 <= 64'(friction_coef) * 64'(pvu_pkg::abs32(c10.latx));
      pfy11 <= 64'(friction_coef) * 64'(pvu_pkg::abs32(c10.laty));
      pmx11 <= 64'(pvu_pkg::abs32(c10.prx)) * 64'(c10.mass);
      pmy11 <= 64'(pvu_pkg::abs32(c10.pry)) * 64'(c10.mass);
    end
  end

  // Stage 12: friction force; numerators over reaction time
  logic [62:0] mnx12, mny12;

  always_ff @(posedge clk) begin
    if (en) begin
      c12     <= c11;
      c12.frx <= pvu_pkg::rnd_q(c11.latx[31], pfx11);
      c12.fry <= pvu_pkg::rnd_q(c11.laty[31], pfy11);
      mnx12   <= 63'(pmx11) + 63'(c11.rt >> 1);
      mny12   <= 63'(pmy11) + 63'(c11.rt >> 1);
    end
  end

  // Stage 13: overflow check of the reaction time division
  logic [62:0] mnx13, mny13;

  always_ff @(posedge clk) begin
    if (en) begin
      c13     <= c12;
      c13.ovx <= (c12.rt == 31'd0) ? (mnx12 != 63'd0) : (mnx12 >= 63'({c12.rt, 31'd0}));
      c13.ovy <= (c12.rt == 31'd0) ? (mny12 != 63'd0) : (mny12 >= 63'({c12.rt, 31'd0}));
      mnx13   <= mnx12;
      mny13   <= mny12;
    end
  end

  logic [30:0]     qmx, qmy;
  logic [CtxW-1:0] cd2_bits;

  pvu_div #(.NW(63), .DW(31), .QW(31), .SW(CtxW)) u_div_rt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v13),
    .in_num_a  (mnx13),
    .in_num_b  (mny13),
    .in_den    (c13.rt),
    .in_side   (c13),
    .out_valid (vd2),
    .out_quo_a (qmx),
    .out_quo_b (qmy),
    .out_side  (cd2_bits)
  );

  assign cd2 = cd2_bits;

  // Stage 14: propulsion force
  logic rtz14;

  assign rtz14 = (cd2.rt == 31'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      c14     <= cd2;
      c14.prx <= pvu_pkg::sub_sat(pvu_pkg::fin_div(cd2.prx[31], cd2.ovx, rtz14, qmx), cd2.frx);
      c14.pry <= pvu_pkg::sub_sat(pvu_pkg::fin_div(cd2.pry[31], cd2.ovy, rtz14, qmy), cd2.fry);
    end
  end

  // Stage 15: numerators over mass
  logic [47:0] anx15, any15;

  always_ff @(posedge clk) begin
    if (en) begin
      c15   <= c14;
      anx15 <= {pvu_pkg::abs32(c14.prx), 16'd0} + 48'(c14.mass >> 1);
      any15 <= {pvu_pkg::abs32(c14.pry), 16'd0} + 48'(c14.mass >> 1);
    end
  end

  // Stage 16: overflow check of the mass division
  logic [47:0] anx16, any16;

  always_ff @(posedge clk) begin
    if (en) begin
      c16     <= c15;
      c16.ovx <= (c15.mass == 31'd0) ? (anx15 != 48'd0)
                                     : (62'(anx15) >= {c15.mass, 31'd0});
      c16.ovy <= (c15.mass == 31'd0) ? (any15 != 48'd0)
                                     : (62'(any15) >= {c15.mass, 31'd0});
      anx16   <= anx15;
      any16   <= any15;
    end
  end

  logic [30:0]     qax, qay;
  logic [CtxW-1:0] cd3_bits;

  pvu_div #(.NW(48), .DW(31), .QW(31), .SW(CtxW)) u_div_mass (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v16),
    .in_num_a  (anx16),
    .in_num_b  (any16),
    .in_den    (c16.mass),
    .in_side   (c16),
    .out_valid (vd3),
    .out_quo_a (qax),
    .out_quo_b (qay),
    .out_side  (cd3_bits)
  );

  assign cd3 = cd3_bits;

  // Stage 17: acceleration
  logic signed [31:0] accx17, accy17;
  logic               mz17;

  assign mz17 = (cd3.mass == 31'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      c17    <= cd3;
      accx17 <= pvu_pkg::fin_div(cd3.prx[31], cd3.ovx, mz17, qax);
      accy17 <= pvu_pkg::fin_div(cd3.pry[31], cd3.ovy, mz17, qay);
    end
  end

  // Stage 18: velocity increment products
  logic [63:0] pax18, pay18;
  logic        sax18, say18;

  always_ff @(posedge clk) begin
    if (en) begin
      c18   <= c17;
      pax18 <= 64'(pvu_pkg::abs32(accx17)) * 64'(time_step);
      pay18 <= 64'(pvu_pkg::abs32(accy17)) * 64'(time_step);
      sax18 <= accx17[31];
      say18 <= accy17[31];
    end
  end

  // Stage 19: new velocity
  always_ff @(posedge clk) begin
    if (en) begin
      c19     <= c18;
      c19.nvx <= pvu_pkg::add_sat(c18.vx, pvu_pkg::rnd_q(sax18, pax18));
      c19.nvy <= pvu_pkg::add_sat(c18.vy, pvu_pkg::rnd_q(say18, pay18));
    end
  end

  // Stage 20: position increment products
  logic [63:0] pnx20, pny20;

  always_ff @(posedge clk) begin
    if (en) begin
      c20   <= c19;
      pnx20 <= 64'(pvu_pkg::abs32(c19.nvx)) * 64'(time_step);
      pny20 <= 64'(pvu_pkg::abs32(c19.nvy)) * 64'(time_step);
    end
  end

  // Stage 21: output register, halted items keep position and stop
  logic signed [31:0] onvx, onvy, onpx, onpy;

  always_ff @(posedge clk) begin
    if (en) begin
      onvx <= c20.halt ? 32'sd0 : c20.nvx;
      onvy <= c20.halt ? 32'sd0 : c20.nvy;
      onpx <= c20.halt ? c20.px
                       : pvu_pkg::add_sat(c20.px, pvu_pkg::rnd_q(c20.nvx[31], pnx20));
      onpy <= c20.halt ? c20.py
                       : pvu_pkg::add_sat(c20.py, pvu_pkg::rnd_q(c20.nvy[31], pny20));
    end
  end

  assign m_axis_tvalid = v21;
  assign m_axis_tdata  = {onpy, onpx, onvy, onvx};

  // Checks
  `PVU_ASSERT_SEQ(a_stall_holds_item, clk, rst, v1 && !en, v1, "item lost in stall")
  `PVU_ASSERT_COMB(a_sqrt_remainder, clk, rst, sq_v[32], sq_x[32] <= (sq_r[32] << 1), "square root remainder too large")
  `PVU_ASSERT_COMB(a_unit_direction, clk, rst, v6, (c6.ux <= 32'sd65536) && (c6.ux >= -32'sd65536) && (c6.uy <= 32'sd65536) && (c6.uy >= -32'sd65536), "direction exceeds unit length")

endmodule

### test/tb_pedestrian_velocity_update.sv
`timescale 1ns / 1ps

module tb_pedestrian_velocity_update;

  localparam int LATENCY = 132;
  localparam int N_RANDOM = 1030;

  typedef struct {
    logic        halt;
    logic [31:0] px, py, vx, vy, gx, gy;
    logic [30:0] spd, mass, rt, slow;
  } ped_t;

  typedef struct {
    bit          known;
    logic [31:0] nvx, nvy, npx, npy;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;

  pedestrian_velocity_update dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copies of the registers
  longint unsigned fric_q = 0;
  longint unsigned step_q = 3277;

  logic [127:0] pending_q[$];
  int           errors = 0;
  bit           rx_hold = 1'b0;

  // ---------------- fixed-point helpers ----------------
  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    if (neg) return m >= 64'd2147483648 ? -64'sd2147483648 : -longint'(m);
    return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = (abs_l(a) * abs_l(b) + 64'h8000) >> 16;
    return signed_of((a < 0) != (b < 0), m);
  endfunction

  function automatic longint scale_div(longint a, longint unsigned b, longint unsigned c);
    longint unsigned num;
    num = abs_l(a) * b;
    if (c == 0) begin
      if (num == 0) return 0;
      return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
    end
    return signed_of(a < 0, (num + c / 2) / c);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // compute the updated velocity and position of one pedestrian
  function automatic logic [127:0] ped_update(ped_t p);
    longint px, py, vx, vy, dx, dy, ux, uy, d, lx, ly, fx, fy, s, qx, qy, ax, ay;
    longint nvx, nvy, npx, npy;
    longint unsigned mx, my, len;
    px = longint'($signed(p.px)); py = longint'($signed(p.py));
    vx = longint'($signed(p.vx)); vy = longint'($signed(p.vy));
    if (p.halt) begin
      nvx = 0; nvy = 0; npx = px; npy = py;
    end else begin
      dx = longint'($signed(p.gx)) - px;
      dy = longint'($signed(p.gy)) - py;
      mx = abs_l(dx); my = abs_l(dy);
      if (mx >= 64'd2147483648 || my >= 64'd2147483648) begin
        mx >>= 1; my >>= 1;
      end
      len = root_floor(mx * mx + my * my);
      ux = 0; uy = 0;
      if (len != 0) begin
        ux = scale_div(dx < 0 ? -longint'(mx) : longint'(mx), 65536, len);
        uy = scale_div(dy < 0 ? -longint'(my) : longint'(my), 65536, len);
      end
      d = sat_word(qmul(vx, ux) + qmul(vy, uy));
      lx = sat_word(vx - qmul(d, ux));
      ly = sat_word(vy - qmul(d, uy));
      fx = qmul(longint'(fric_q), lx);
      fy = qmul(longint'(fric_q), ly);
      s = qmul(longint'(p.spd), longint'(p.slow));
      qx = sat_word(scale_div(sat_word(qmul(ux, s) - vx), p.mass, p.rt) - fx);
      qy = sat_word(scale_div(sat_word(qmul(uy, s) - vy), p.mass, p.rt) - fy);
      ax = scale_div(qx, 65536, p.mass);
      ay = scale_div(qy, 65536, p.mass);
      nvx = sat_word(vx + qmul(ax, longint'(step_q)));
      nvy = sat_word(vy + qmul(ay, longint'(step_q)));
      npx = sat_word(px + qmul(nvx, longint'(step_q)));
      npy = sat_word(py + qmul(nvy, longint'(step_q)));
    end
    return {npy[31:0], npx[31:0], nvy[31:0], nvx[31:0]};
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rnd_field(bit positive);
    logic [30:0] v;
    case ($urandom_range(0, 5))
      0: v = 31'h7FFF_FFFF;
      1: v = positive ? 31'd1 : 31'd0;
      2: v = 31'($urandom_range(1, 400000));
      default: v = 31'($urandom);
    endcase
    if (positive && v == 0) v = 31'd1;
    return v;
  endfunction

  // drop valid only when a gap follows
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // send one pedestrian beat and queue its expected result
  task automatic send_ped(ped_t p, row_t r);
    idle_gap();
    s_axis_tdata <= {4'b0, p.slow, p.rt, p.mass, p.spd, p.gy, p.gx, p.vy, p.vx, p.py, p.px};
    s_axis_tuser <= p.halt;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (r.known) pending_q.push_back({r.npy, r.npx, r.nvy, r.nvx});
    else pending_q.push_back(ped_update(p));
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == pvu_pkg::CFG_FRICTION_COEF) fric_q = val[30:0];
    else step_q = val[30:0];
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic ped_t rnd_ped();
    ped_t p;
    p.halt = ($urandom_range(0, 7) == 0);
    p.px = rnd_word(); p.py = rnd_word();
    p.vx = rnd_word(); p.vy = rnd_word();
    if ($urandom_range(0, 9) == 0) begin
      p.gx = p.px; p.gy = p.py;
    end else begin
      p.gx = rnd_word(); p.gy = rnd_word();
    end
    p.spd = rnd_field(0); p.mass = rnd_field(1);
    p.rt = rnd_field(1); p.slow = rnd_field(0);
    return p;
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(0, 3) != 0;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = pending_q.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (want[f*32 +: 32] !== m_axis_tdata[f*32 +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
              errors++;
            end
          end
        end
      end
      m_axis_tready <= !rx_hold;
    end
  end

  // ---------------- directed table ----------------
  ped_t dir_ped[$];
  row_t dir_row[$];

  task automatic add_row(ped_t p, row_t r);
    dir_ped.push_back(p);
    dir_row.push_back(r);
  endtask

  initial begin
    ped_t p;
    row_t r, unk;
    unk = '{known: 1'b0, default: '0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // halted pedestrians: zero velocity, position kept
    p = '{halt: 1'b1, px: 32'h7FFF_FFFF, py: 32'h8000_0000, vx: 32'h1234_5678,
          vy: 32'hFFFF_0000, gx: 32'h0, gy: 32'h0, spd: 31'h7FFF_FFFF,
          mass: 31'h7FFF_FFFF, rt: 31'd1, slow: 31'h7FFF_FFFF};
    r = '{known: 1'b1, nvx: 0, nvy: 0, npx: 32'h7FFF_FFFF, npy: 32'h8000_0000};
    add_row(p, r);
    p.px = 32'h8000_0000; p.py = 32'h7FFF_FFFF;
    r.npx = 32'h8000_0000; r.npy = 32'h7FFF_FFFF;
    add_row(p, r);
    // at rest on the goal with unit desired speed: stays put
    p = '{halt: 1'b0, px: 32'h0001_0000, py: 32'hFFFE_0000, vx: 0, vy: 0,
          gx: 32'h0001_0000, gy: 32'hFFFE_0000, spd: 31'h0001_0000,
          mass: 31'h0001_0000, rt: 31'h0001_0000, slow: 31'h0001_0000};
    r = '{known: 1'b1, nvx: 0, nvy: 0, npx: 32'h0001_0000, npy: 32'hFFFE_0000};
    add_row(p, r);
    // goal extremes, opposite corners: halved difference
    p = '{halt: 1'b0, px: 32'h8000_0000, py: 32'h8000_0000, vx: 32'h7FFF_FFFF,
          vy: 32'h8000_0000, gx: 32'h7FFF_FFFF, gy: 32'h7FFF_FFFF,
          spd: 31'h7FFF_FFFF, mass: 31'h7FFF_FFFF, rt: 31'd1, slow: 31'h7FFF_FFFF};
    add_row(p, unk);
    p.px = 32'h7FFF_FFFF; p.gx = 32'h8000_0000; p.gy = 32'h0;
    add_row(p, unk);
    // small mass, large reaction time
    p = '{halt: 1'b0, px: 0, py: 0, vx: 32'h0002_0000, vy: 32'hFFFF_8000,
          gx: 32'h000A_0000, gy: 32'h0005_0000, spd: 31'h0001_4000,
          mass: 31'd1, rt: 31'h7FFF_FFFF, slow: 31'h0000_8000};
    add_row(p, unk);
    p.mass = 31'h0048_0000; p.rt = 31'h0000_8000; p.slow = 0; p.spd = 0;
    add_row(p, unk);
    p.vx = 32'h8000_0000; p.vy = 32'h7FFF_FFFF; p.gx = 0; p.gy = 32'hFFF0_0000;
    add_row(p, unk);

    for (int i = 0; i < dir_ped.size(); i++) send_ped(dir_ped[i], dir_row[i]);
    drain();

    // register settings: extremes and typical values
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, 32'h0000_8000);
                 write_reg(pvu_pkg::CFG_TIME_STEP, 32'h0000_0CCD); end
        1: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, 32'hFFFF_FFFF);
                 write_reg(pvu_pkg::CFG_TIME_STEP, 32'h7FFF_FFFF); end
        2: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, 32'h0);
                 write_reg(pvu_pkg::CFG_TIME_STEP, 32'd1); end
        3: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, $urandom);
                 write_reg(pvu_pkg::CFG_TIME_STEP,
                           32'h8000_0000 | $urandom_range(1, 65536)); end
        4: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, 32'h0002_0000);
                 write_reg(pvu_pkg::CFG_TIME_STEP, 32'h0001_0000); end
        default: begin write_reg(pvu_pkg::CFG_FRICTION_COEF, $urandom_range(0, 200000));
                 write_reg(pvu_pkg::CFG_TIME_STEP, $urandom_range(1, 20000)); end
      endcase
      // one time-step-free pass: step field zero only through masking
      if (phase == 2) begin
        write_reg(pvu_pkg::CFG_TIME_STEP, 32'h8000_0000);
        for (int k = 0; k < 10; k++) send_ped(rnd_ped(), unk);
        drain();
        write_reg(pvu_pkg::CFG_TIME_STEP, 32'd1);
      end
      for (int k = 0; k < N_RANDOM / 6; k++) send_ped(rnd_ped(), unk);
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
